// ===== rtl/vlrq_pkg.sv =====
// shared types, constants and helpers for the variable-length ring queue
// used by vlrq_alu, vlrq_hdr_ram and variable_length_ring_queue; no dependencies
package vlrq_pkg;

  // ring geometry
  localparam int QUEUE_BYTES    = 4096;
  localparam int ADDR_W         = $clog2(QUEUE_BYTES);
  localparam int PTR_W          = 13;
  localparam int ALU_W          = PTR_W + 2;
  localparam int BASE_HDR_BYTES = 16;
  localparam int REC_HDR_BYTES  = 24;
  localparam int PAD_TYPE_CODE  = 1;

  // register reset values
  localparam logic [PTR_W-1:0] QLEN_RESET = PTR_W'(4096);
  localparam logic [PTR_W-1:0] MAXP_RESET = PTR_W'(1024);

  localparam logic [PTR_W-1:0] RING_MAX   = PTR_W'(QUEUE_BYTES);
  localparam logic [PTR_W-1:0] BASE_OFF   = PTR_W'(BASE_HDR_BYTES);
  localparam logic [PTR_W-1:0] REC_HDR    = PTR_W'(REC_HDR_BYTES);
  localparam logic [PTR_W-1:0] CNT_MAX    = {PTR_W{1'b1}};
  localparam logic [7:0]       PAD_TYPE   = 8'(PAD_TYPE_CODE);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_TOO_LARGE = 3'd3,
    STAT_TOO_SHORT = 3'd4
  } status_e;

  typedef enum logic {
    CFG_QUEUE_LENGTH = 1'b0,
    CFG_MAX_PACKET   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LEN_MIN,
    S_LEN_MAX,
    S_SURPLUS,
    S_FIT,
    S_WRAP,
    S_GAP,
    S_GUARD_CMP,
    S_GUARD_SUM,
    S_GUARD_MAX,
    S_GUARD_CHK,
    S_STORE,
    S_POP_CMP,
    S_POP_EDGE,
    S_POP_SKIP,
    S_POP_EMPTY,
    S_POP_READ,
    S_POP_ADV,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e         opcode;
    logic [12:0] block_length;
    logic [7:0]  block_type;
    logic [31:0] block_id;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        recovered;
    logic [11:0] offset;
    logic [12:0] out_length;
    logic [7:0]  out_type;
    logic [31:0] out_id;
    logic [12:0] record_count;
  } out_item_t;

  typedef struct packed {
    logic [12:0] len;
    logic [7:0]  typ;
    logic [31:0] id;
  } hdr_t;

  // zero-extend a pointer-wide value into the signed alu width
  function automatic logic signed [ALU_W-1:0] to_alu(input logic [PTR_W-1:0] x);
    return $signed({{(ALU_W-PTR_W){1'b0}}, x});
  endfunction

endpackage

// ===== rtl/vlrq_alu.sv =====
// shared add / subtract-compare unit of the ring queue sequencer
// depends on vlrq_pkg
module vlrq_alu (
  input  vlrq_pkg::alu_op_e                   op_i,
  input  logic signed [vlrq_pkg::ALU_W-1:0]   a_i,
  input  logic signed [vlrq_pkg::ALU_W-1:0]   b_i,
  output logic signed [vlrq_pkg::ALU_W-1:0]   y_o,
  output logic                                lt_o
);
  import vlrq_pkg::*;

  // one adder, b inverted for subtract
  always_comb begin
    unique case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i - b_i;
    endcase
  end

  // a below b when the difference is negative
  assign lt_o = (op_i == ALU_SUB) && y_o[ALU_W-1];

endmodule

// ===== rtl/vlrq_hdr_ram.sv =====
// header store: one record header per byte offset, registered read
// depends on vlrq_pkg; offsets past the ring drop writes and read as zero
module vlrq_hdr_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [vlrq_pkg::PTR_W-1:0]    waddr_i,
  input  vlrq_pkg::hdr_t                wdata_i,
  input  logic                          re_i,
  input  logic [vlrq_pkg::PTR_W-1:0]    raddr_i,
  output vlrq_pkg::hdr_t                rdata_o
);
  import vlrq_pkg::*;

  hdr_t mem [QUEUE_BYTES];
  hdr_t rd_q;
  logic oob_q;
  logic w_in_range;
  logic r_in_range;

  assign w_in_range = {1'b0, waddr_i} < (PTR_W+1)'(QUEUE_BYTES);
  assign r_in_range = {1'b0, raddr_i} < (PTR_W+1)'(QUEUE_BYTES);

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i && w_in_range) begin
      mem[waddr_i[ADDR_W-1:0]] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q  <= mem[raddr_i[ADDR_W-1:0]];
      oob_q <= !r_in_range;
    end
  end

  assign rdata_o = oob_q ? '0 : rd_q;

endmodule

// ===== rtl/variable_length_ring_queue.sv =====
// top level of the variable-length record ring queue: sequencer, pointers, count
// depends on vlrq_pkg, vlrq_alu and vlrq_hdr_ram
//
// Usage: the input channel carries one item per operation, a push (store a
// record header, get its byte offset) or a pop (get the oldest header and its
// offset). Each item yields exactly one result item on the output channel with
// a status, the offset, the popped header and the record count afterwards.
// The caller copies payload bytes itself at the returned offset.
// A push is checked on length, may then wrap the ring and check the guard
// window, and stores its header; a pop may skip the ring end, then reads and
// hands out the tail header unless the queue is empty. One item is worked on
// at a time and the next one is accepted the cycle after the result is loaded.
// The sequencer steps every compare and add through one shared adder and reads
// headers through the registered read port of the header memory.
// Input stall is high from accept until the result is handed to the output
// register; that register holds the result while the receiver stalls, and the
// next item is accepted meanwhile, finishing in the done step until free.
// Reset puts head and tail at the base header size, clears the count and loads
// queue_length 4096, max_packet 1024. The header memory is not cleared.
// Configuration writes take effect at once; the user must make them only while idle, the block does not enforce it.
module variable_length_ring_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  vlrq_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vlrq_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  vlrq_pkg::cfg_idx_e                cfg_idx_i,
  input  logic [vlrq_pkg::PTR_W-1:0]        cfg_data_i
);
  import vlrq_pkg::*;

  state_e    state_q, state_d;
  in_item_t  item_q, item_d;
  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [PTR_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] ring_len_q;
  logic [PTR_W-1:0] maxp_q;
  logic signed [ALU_W-1:0] acc_q, acc_d;

  alu_op_e                 alu_op;
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic                    alu_lt;

  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  hdr_t             ram_wdata, ram_rdata;

  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  vlrq_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y),
    .lt_o (alu_lt)
  );

  vlrq_hdr_ram u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_item_i.opcode == OP_PUSH) ? S_LEN_MIN : S_POP_CMP;
        end
      end
      S_LEN_MIN:   state_d = alu_lt ? S_DONE : S_LEN_MAX;
      S_LEN_MAX:   state_d = alu_lt ? S_DONE : S_SURPLUS;
      S_SURPLUS:   state_d = S_FIT;
      S_FIT: begin
        if (!alu_lt) begin
          state_d = S_GUARD_CMP;
        end else if (tail_q == BASE_OFF) begin
          state_d = S_DONE;
        end else begin
          state_d = S_WRAP;
        end
      end
      S_WRAP:      state_d = alu_lt ? S_GUARD_CMP : S_GAP;
      S_GAP:       state_d = S_GUARD_CMP;
      S_GUARD_CMP: state_d = alu_lt ? S_GUARD_SUM : S_STORE;
      S_GUARD_SUM: state_d = S_GUARD_MAX;
      S_GUARD_MAX: state_d = S_GUARD_CHK;
      S_GUARD_CHK: state_d = alu_lt ? S_DONE : S_STORE;
      S_STORE:     state_d = S_DONE;
      S_POP_CMP:   state_d = alu_lt ? S_POP_EDGE : S_POP_EMPTY;
      S_POP_EDGE:  state_d = S_POP_SKIP;
      S_POP_SKIP:  state_d = S_POP_EMPTY;
      S_POP_EMPTY: state_d = (tail_q == head_q) ? S_DONE : S_POP_READ;
      S_POP_READ:  state_d = alu_lt ? S_DONE : S_POP_ADV;
      S_POP_ADV:   state_d = S_DONE;
      S_DONE:      state_d = out_free ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath control and next values
  always_comb begin
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    acc_d       = acc_q;
    alu_op      = ALU_SUB;
    alu_a       = '0;
    alu_b       = '0;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = tail_q;

    // output register drains when taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          res_d  = '0;
        end
      end
      // length below the record header
      S_LEN_MIN: begin
        alu_a = to_alu(item_q.block_length);
        alu_b = to_alu(REC_HDR);
        if (alu_lt) res_d.status = STAT_TOO_SHORT;
      end
      // length above max_packet
      S_LEN_MAX: begin
        alu_a = to_alu(maxp_q);
        alu_b = to_alu(item_q.block_length);
        if (alu_lt) res_d.status = STAT_TOO_LARGE;
      end
      // room left before the ring end
      S_SURPLUS: begin
        alu_a = to_alu(ring_len_q);
        alu_b = to_alu(head_q);
        acc_d = alu_y;
      end
      S_FIT: begin
        alu_a = acc_q;
        alu_b = to_alu(item_q.block_length);
        if (alu_lt && tail_q == BASE_OFF) res_d.status = STAT_FULL;
      end
      // tail beyond head at wrap: reset both pointers
      S_WRAP: begin
        alu_a = to_alu(head_q);
        alu_b = to_alu(tail_q);
        if (alu_lt) begin
          head_d          = BASE_OFF;
          tail_d          = BASE_OFF;
          res_d.recovered = 1'b1;
        end
      end
      // short end gap is skipped, a larger one gets a pad header
      S_GAP: begin
        alu_a  = acc_q;
        alu_b  = to_alu(REC_HDR);
        head_d = BASE_OFF;
        if (!alu_lt) begin
          ram_we    = 1'b1;
          ram_wdata = '{len: acc_q[PTR_W-1:0], typ: PAD_TYPE, id: '0};
        end
      end
      // guard window applies only with tail ahead of head
      S_GUARD_CMP: begin
        alu_a = to_alu(head_q);
        alu_b = to_alu(tail_q);
      end
      S_GUARD_SUM: begin
        alu_op = ALU_ADD;
        alu_a  = to_alu(head_q);
        alu_b  = to_alu(item_q.block_length);
        acc_d  = alu_y;
      end
      S_GUARD_MAX: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = to_alu(maxp_q);
        acc_d  = alu_y;
      end
      S_GUARD_CHK: begin
        alu_a = to_alu(tail_q);
        alu_b = acc_q;
        if (alu_lt) res_d.status = STAT_FULL;
      end
      // store header and advance head
      S_STORE: begin
        alu_op       = ALU_ADD;
        alu_a        = to_alu(head_q);
        alu_b        = to_alu(item_q.block_length);
        head_d       = alu_y[PTR_W-1:0];
        ram_we       = 1'b1;
        ram_wdata    = '{len: item_q.block_length, typ: item_q.block_type,
                         id: item_q.block_id};
        res_d.offset = head_q[11:0];
        if (count_q != CNT_MAX) count_d = count_q + PTR_W'(1);
      end
      // head behind tail: look at the tail header for a skip
      S_POP_CMP: begin
        alu_a = to_alu(head_q);
        alu_b = to_alu(tail_q);
        if (alu_lt) ram_re = 1'b1;
      end
      S_POP_EDGE: begin
        alu_a = to_alu(ring_len_q);
        alu_b = to_alu(tail_q);
        acc_d = alu_y;
      end
      S_POP_SKIP: begin
        alu_a = acc_q;
        alu_b = to_alu(REC_HDR);
        if (alu_lt || ram_rdata.typ == PAD_TYPE) tail_d = BASE_OFF;
      end
      S_POP_EMPTY: begin
        if (tail_q == head_q) begin
          res_d.status = STAT_EMPTY;
        end else begin
          ram_re = 1'b1;
        end
      end
      // stored length check, then hand out the header
      S_POP_READ: begin
        alu_a = to_alu(maxp_q);
        alu_b = to_alu(ram_rdata.len);
        if (alu_lt) begin
          res_d.status = STAT_TOO_LARGE;
        end else begin
          res_d.offset     = tail_q[11:0];
          res_d.out_length = ram_rdata.len;
          res_d.out_type   = ram_rdata.typ;
          res_d.out_id     = ram_rdata.id;
          if (count_q != '0) count_d = count_q - PTR_W'(1);
        end
      end
      S_POP_ADV: begin
        alu_op = ALU_ADD;
        alu_a  = to_alu(tail_q);
        alu_b  = to_alu(ram_rdata.len);
        tail_d = alu_y[PTR_W-1:0];
      end
      S_DONE: begin
        if (out_free) begin
          out_d              = res_q;
          out_d.record_count = count_q;
          out_valid_d        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= BASE_OFF;
      tail_q      <= BASE_OFF;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
    end
  end

  // configuration registers, ring length clamped to the store size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_len_q <= (QLEN_RESET > RING_MAX) ? RING_MAX : QLEN_RESET;
      maxp_q     <= MAXP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_QUEUE_LENGTH: ring_len_q <= (cfg_data_i > RING_MAX) ? RING_MAX : cfg_data_i;
        CFG_MAX_PACKET:   maxp_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
    acc_q  <= acc_d;
  end

  // count moves only when a record is stored or handed out
  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_STORE && state_q != S_POP_READ) |=> $stable(count_q))
    else $error("record count changed outside store or pop");

  // a pop never moves the head
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_CMP || state_q == S_POP_EDGE || state_q == S_POP_SKIP ||
     state_q == S_POP_EMPTY || state_q == S_POP_READ || state_q == S_POP_ADV)
    |=> $stable(head_q))
    else $error("head moved during a pop");

  // output register is loaded only from the done step
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside the done step");

  // failed operations report offset zero
  a_fail_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != STAT_OK) |-> out_item_o.offset == '0)
    else $error("failed item carries an offset");

endmodule
